### design/atu_pkg.sv
// Shared types, constants and helpers for the alarm timer unit.
package atu_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int IDX_W     = (SLOT_W > 4) ? SLOT_W : 4;
  localparam int TICK_W    = 16;
  localparam int MAX_FIRED = 16;
  localparam int FIRED_W   = $clog2(MAX_FIRED + 1);

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_CANCEL     = 2'd2,
    CMD_CANCEL_ALL = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_ZERO_DELAY = 3'd2,
    KIND_FIRED      = 3'd3,
    KIND_DONE       = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_TSCAN,
    ST_TCALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [3:0] slot;
    logic       last;
  } emit_t;

  // Slot numbers are reported modulo sixteen.
  function automatic logic [3:0] slot_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+3:0] t;
    t = {4'b0000, c};
    return t[3:0];
  endfunction

endpackage

### design/multi_slot_alarm_timer_unit.sv
// Alarm timer unit top level: sequencer, slot RAM, decrement unit, output register.
//
// The unit keeps SLOTS (16) alarm slots, each a 16-bit count in a RAM plus an
// active flag in flip-flops, so reset and cancel-all free every slot at once
// and no clearing pass is needed. One command is taken at a time; in_stall is
// high until its last result has been moved into the output register. A zero
// delay or a cancel goes straight to its result, with no slot sweep. A register
// command scans the active flags one slot per cycle from slot 0 and stops at
// the lowest free slot, or at the end of the table when it is full. A tick
// sweeps the slots with one shared decrement unit: a free slot is skipped and
// an active slot takes a RAM read, then decrement and write back. The sweep
// holds while a fired result waits on a stalled output side. Each fired result
// has last low; every command ends with exactly one result with last high.
module multi_slot_alarm_timer_unit import atu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_delay_ticks,
  input  logic [3:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [3:0]  out_slot_number,
  output logic        out_last
);

  emit_t             emit;
  logic              out_free;
  logic              ram_wr_en;
  logic [SLOT_W-1:0] ram_wr_addr;
  logic [TICK_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [SLOT_W-1:0] ram_rd_addr;
  logic [TICK_W-1:0] ram_rd_data;
  logic [TICK_W-1:0] dec_q;
  logic              dec_zero;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r;
  logic [3:0]        out_slot_r;
  logic              out_last_r;

  atu_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_command     (in_command),
    .in_delay_ticks (in_delay_ticks),
    .in_slot_index  (in_slot_index),
    .in_stall       (in_stall),
    .out_free       (out_free),
    .emit           (emit),
    .ram_wr_en      (ram_wr_en),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_en      (ram_rd_en),
    .ram_rd_addr    (ram_rd_addr),
    .dec_q          (dec_q),
    .dec_zero       (dec_zero)
  );

  atu_ram #(
    .WIDTH (TICK_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  atu_dec u_dec (
    .a    (ram_rd_data),
    .q    (dec_q),
    .zero (dec_zero)
  );

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_kind_r <= emit.kind;
      out_slot_r <= emit.slot;
      out_last_r <= emit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_kind_r;
  assign out_slot_number = out_slot_r;
  assign out_last        = out_last_r;

endmodule

### design/atu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module atu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/atu_dec.sv
// Shared decrement unit with a reached-zero flag for the tick sweep.
module atu_dec import atu_pkg::*; (
  input  logic [TICK_W-1:0] a,
  output logic [TICK_W-1:0] q,
  output logic              zero
);

  assign q    = a - TICK_W'(1);
  assign zero = (a == TICK_W'(1));

endmodule

### design/atu_ctrl.sv
// Sequencer: command decode, slot sweep, active flags and result requests.
module atu_ctrl import atu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_command,
  input  logic [15:0]       in_delay_ticks,
  input  logic [3:0]        in_slot_index,
  output logic              in_stall,
  input  logic              out_free,
  output emit_t             emit,
  output logic              ram_wr_en,
  output logic [SLOT_W-1:0] ram_wr_addr,
  output logic [TICK_W-1:0] ram_wr_data,
  output logic              ram_rd_en,
  output logic [SLOT_W-1:0] ram_rd_addr,
  input  logic [TICK_W-1:0] dec_q,
  input  logic              dec_zero
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [FIRED_W-1:0]  fired_r, fired_nxt;
  logic [TICK_W-1:0]   delay_r, delay_nxt;
  kind_t               res_kind_r, res_kind_nxt;
  logic [3:0]          res_slot_r, res_slot_nxt;
  logic [SLOTS-1:0]    active_r, active_nxt;

  logic                accept;
  cmd_t                cmd_in;
  logic [IDX_W-1:0]    cancel_idx;
  logic [SLOT_W-1:0]   cur;
  logic                at_end;
  logic                fire_report;

  assign accept      = in_valid && (state_r == ST_IDLE);
  assign in_stall    = (state_r != ST_IDLE);
  assign cmd_in      = cmd_t'(in_command);
  assign cancel_idx  = IDX_W'(in_slot_index);
  assign cur         = cnt_r[SLOT_W-1:0];
  assign at_end      = (cnt_r == CNT_W'(SLOTS));
  assign fire_report = dec_zero && (fired_r != FIRED_W'(MAX_FIRED));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_REGISTER: state_nxt = (in_delay_ticks == '0) ? ST_EMIT : ST_FIND;
            CMD_TICK:     state_nxt = ST_TSCAN;
            default:      state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_FIND: begin
        if (at_end || !active_r[cur]) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_TSCAN: begin
        if (at_end) begin
          state_nxt = ST_EMIT;
        end else if (active_r[cur]) begin
          state_nxt = ST_TCALC;
        end
      end
      ST_TCALC: begin
        if (!fire_report || out_free) begin
          state_nxt = ST_TSCAN;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    fired_nxt    = fired_r;
    delay_nxt    = delay_r;
    res_kind_nxt = res_kind_r;
    res_slot_nxt = res_slot_r;
    active_nxt   = active_r;
    emit         = '{valid: 1'b0, kind: KIND_DONE, slot: 4'd0, last: 1'b1};
    ram_wr_en    = 1'b0;
    ram_wr_addr  = cur;
    ram_wr_data  = dec_q;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = cur;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt      = '0;
          fired_nxt    = '0;
          delay_nxt    = in_delay_ticks;
          res_kind_nxt = KIND_DONE;
          res_slot_nxt = 4'd0;
          case (cmd_in)
            CMD_REGISTER: begin
              if (in_delay_ticks == '0) begin
                res_kind_nxt = KIND_ZERO_DELAY;
              end
            end
            CMD_TICK: ;
            CMD_CANCEL: begin
              // An index past the table is ignored; a free slot stays free.
              if (int'(in_slot_index) < SLOTS) begin
                active_nxt[cancel_idx[SLOT_W-1:0]] = 1'b0;
              end
            end
            default: active_nxt = '0;
          endcase
        end
      end
      ST_FIND: begin
        if (at_end) begin
          res_kind_nxt = KIND_FULL;
        end else if (!active_r[cur]) begin
          ram_wr_en         = 1'b1;
          ram_wr_data       = delay_r;
          active_nxt[cur]   = 1'b1;
          res_kind_nxt      = KIND_REGISTERED;
          res_slot_nxt      = slot_field(cnt_r);
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_TSCAN: begin
        if (!at_end) begin
          if (active_r[cur]) begin
            ram_rd_en = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_TCALC: begin
        // Hold the slot untouched while a fired result waits for the output.
        if (!fire_report || out_free) begin
          ram_wr_en = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          if (dec_zero) begin
            active_nxt[cur] = 1'b0;
          end
          if (fire_report) begin
            emit      = '{valid: 1'b1, kind: KIND_FIRED, slot: slot_field(cnt_r), last: 1'b0};
            fired_nxt = fired_r + FIRED_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = '{valid: 1'b1, kind: res_kind_r, slot: res_slot_r, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= '0;
      cnt_r    <= '0;
      fired_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
      fired_r  <= fired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delay_r    <= delay_nxt;
    res_kind_r <= res_kind_nxt;
    res_slot_r <= res_slot_nxt;
  end

endmodule

### design/atu_checker.sv
// Port-level checks for the alarm timer unit, bound to the top level.
module atu_checker import atu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_command,
  input logic [15:0] in_delay_ticks,
  input logic [3:0]  in_slot_index,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_event_kind,
  input logic [3:0]  out_slot_number,
  input logic        out_last
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind)
      && $stable(out_slot_number) && $stable(out_last))
    else $error("stalled result changed");

  // Only fired events come before the final result of a command.
  a_not_last_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_event_kind == KIND_FIRED)
    else $error("non-final result is not a fired event");

  a_last_not_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_event_kind != KIND_FIRED)
    else $error("final result is a fired event");

  // Results that name no slot carry slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == KIND_FULL || out_event_kind == KIND_ZERO_DELAY
      || out_event_kind == KIND_DONE) |-> out_slot_number == 4'd0)
    else $error("slot number set on a result without a slot");

  // The unit is busy right after taking a command.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command transfer not followed by busy");

endmodule

bind multi_slot_alarm_timer_unit atu_checker u_atu_checker (.*);

### bench/multi_slot_alarm_timer_unit_tb.sv
// Self-checking testbench for the multi-slot alarm timer unit.
module multi_slot_alarm_timer_unit_tb;
  import atu_pkg::*;

  localparam int HOLD_LEN       = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct {
    kind_t      kind;
    logic [3:0] slot;
    logic       last;
  } timer_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_TICK;
  logic [15:0] in_delay_ticks = '0;
  logic [3:0]  in_slot_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_kind;
  logic [3:0]  out_slot_number;
  logic        out_last;

  // Shadow copy of the slot table; zero marks a free slot.
  logic [TICK_W-1:0] slot_ticks [SLOTS];
  timer_event_t      pending_events [$];

  int   send_idle_pct  = 32;
  int   recv_stall_pct = 82;
  int   fail_count     = 0;
  int   quiet_cycles   = 0;
  logic hold_req       = 1'b0;
  int   hold_left      = 0;
  logic hold_armed     = 1'b0;

  multi_slot_alarm_timer_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_delay_ticks  (in_delay_ticks),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_slot_number (out_slot_number),
    .out_last        (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic queue_event(kind_t kind, logic [3:0] slot, logic last);
    timer_event_t ev;
    ev.kind = kind;
    ev.slot = slot;
    ev.last = last;
    pending_events.push_back(ev);
  endtask

  // Updates the shadow table for one accepted command and queues its results.
  task automatic predict_command(cmd_t cmd, logic [15:0] delay, logic [3:0] idx);
    int   fired;
    logic placed;
    fired  = 0;
    placed = 1'b0;
    case (cmd)
      CMD_REGISTER: begin
        if (delay == '0) begin
          queue_event(KIND_ZERO_DELAY, 4'd0, 1'b1);
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && slot_ticks[i] == '0) begin
              slot_ticks[i] = delay;
              queue_event(KIND_REGISTERED, 4'(i), 1'b1);
              placed = 1'b1;
            end
          end
          if (!placed) queue_event(KIND_FULL, 4'd0, 1'b1);
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_ticks[i] != '0) begin
            slot_ticks[i] = slot_ticks[i] - 1'b1;
            if (slot_ticks[i] == '0 && fired < MAX_FIRED) begin
              queue_event(KIND_FIRED, 4'(i), 1'b0);
              fired++;
            end
          end
        end
        queue_event(KIND_DONE, 4'd0, 1'b1);
      end
      CMD_CANCEL: begin
        if (int'(idx) < SLOTS) slot_ticks[idx] = '0;
        queue_event(KIND_DONE, 4'd0, 1'b1);
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) slot_ticks[i] = '0;
        queue_event(KIND_DONE, 4'd0, 1'b1);
      end
    endcase
  endtask

  // Offers one command and returns at the edge where the transfer happens.
  task automatic send_command(cmd_t cmd, logic [15:0] delay, logic [3:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_delay_ticks <= delay;
    in_slot_index  <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(cmd, delay, idx);
  endtask

  // Result side: checks each transfer, then picks the stall for the next cycle.
  always @(posedge clk) begin
    timer_event_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $error("unexpected result: event_kind %0d slot_number %0d last %0d",
                 out_event_kind, out_slot_number, out_last);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          if (out_event_kind !== 3'(want.kind)) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, out_event_kind);
            fail_count++;
          end
          if (out_slot_number !== want.slot) begin
            $error("slot_number: expected %0d, actual %0d", want.slot, out_slot_number);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (hold_req && !hold_armed) begin
        hold_left  = HOLD_LEN;
        hold_armed = 1'b1;
      end else if (!hold_req) begin
        hold_armed = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Ends the run if neither channel makes a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_register_and_fire();
    send_command(CMD_REGISTER, 16'd0, 4'hF);
    send_command(CMD_TICK, 16'hFFFF, 4'hF);
    send_command(CMD_CANCEL, 16'h0000, 4'd5);
    send_command(CMD_REGISTER, 16'd1, 4'h0);
    send_command(CMD_REGISTER, 16'hFFFF, 4'h0);
    send_command(CMD_REGISTER, 16'd2, 4'hA);
    send_command(CMD_TICK, 16'h5555, 4'h5);
    send_command(CMD_CANCEL, 16'hAAAA, 4'd1);
    send_command(CMD_TICK, 16'h0000, 4'h0);
  endtask

  // Fills every slot with the same delay so that one tick fires them all,
  // with the result side held off while the next commands are offered.
  task automatic test_full_table_burst();
    send_command(CMD_CANCEL_ALL, 16'h1234, 4'h9);
    for (int i = 0; i < SLOTS; i++) send_command(CMD_REGISTER, 16'd1, 4'(i));
    send_command(CMD_REGISTER, 16'hFFFF, 4'h0);
    hold_req <= 1'b1;
    send_command(CMD_TICK, 16'h0000, 4'h0);
    send_command(CMD_REGISTER, 16'd3, 4'h0);
    send_command(CMD_TICK, 16'hFFFF, 4'hF);
    hold_req <= 1'b0;
    send_command(CMD_CANCEL_ALL, 16'h0000, 4'h0);
  endtask

  task automatic test_random_traffic(int count);
    int          roll;
    int          n;
    int          burst;
    logic [15:0] delay;
    n = 0;
    while (n < count) begin
      roll = $urandom_range(99);
      if (roll < 36) begin
        roll = $urandom_range(19);
        if (roll == 0) delay = '0;
        else if (roll < 3) delay = 16'($urandom());
        else delay = 16'($urandom_range(1, 6));
        send_command(CMD_REGISTER, delay, 4'($urandom()));
        n++;
      end else if (roll < 41) begin
        // A burst of short alarms drives the table toward full.
        burst = $urandom_range(4, 12);
        for (int b = 0; b < burst; b++) begin
          send_command(CMD_REGISTER, 16'($urandom_range(1, 8)), 4'($urandom()));
          n++;
        end
      end else if (roll < 82) begin
        send_command(CMD_TICK, 16'($urandom()), 4'($urandom()));
        n++;
      end else if (roll < 97) begin
        send_command(CMD_CANCEL, 16'($urandom()), 4'($urandom()));
        n++;
      end else begin
        send_command(CMD_CANCEL_ALL, 16'($urandom()), 4'($urandom()));
        n++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_ticks[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 32;
    recv_stall_pct = 82;
    test_register_and_fire();
    test_full_table_burst();
    test_random_traffic(113);

    send_idle_pct  = 82;
    recv_stall_pct = 32;
    test_random_traffic(113);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(113);

    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
